// ===== src/u2e_pkg.sv =====
package u2e_pkg;

	// APB register map: one register, word aligned
	localparam int unsigned AddrWidth = 3;
	localparam int unsigned DataWidth = 32;
	localparam logic [0:0]  RegLittleEndian = 1'b0;

	// Encoding modes
	typedef enum logic {
		MODE_UTF8  = 1'b0,
		MODE_UTF16 = 1'b1
	} mode_t;

	// Classification bounds
	localparam logic [31:0] Utf8Limit1   = 32'h0000_0080;
	localparam logic [31:0] Utf8Limit2   = 32'h0000_0800;
	localparam logic [31:0] Utf8Limit3   = 32'h0001_0000;
	localparam logic [20:0] SupplBase    = 21'h1_0000;

	// Lead and continuation markers
	localparam logic [7:0]  Utf8Lead2    = 8'hC0;
	localparam logic [7:0]  Utf8Lead3    = 8'hE0;
	localparam logic [7:0]  Utf8Lead4    = 8'hF0;
	localparam logic [7:0]  Utf8Cont     = 8'h80;
	localparam logic [15:0] HighSurr     = 16'hD800;
	localparam logic [15:0] LowSurr      = 16'hDC00;

	// One emitted unit with its side fields
	typedef struct packed {
		logic [15:0] unit_value;
		logic [2:0]  unit_count;
		logic        last;
		logic        error;
	} unit_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

endpackage

// ===== src/u2e_if.sv =====
interface u2e_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] code_word;
	logic        mode;
	logic [2:0]  room;

	modport source (output valid, code_word, mode, room, input ready);
	modport sink   (input valid, code_word, mode, room, output ready);
endinterface

interface u2e_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] unit_value;
	logic [2:0]  unit_count;
	logic        last;
	logic        error;

	modport source (output valid, unit_value, unit_count, last, error, input ready);
	modport sink   (input valid, unit_value, unit_count, last, error, output ready);
endinterface

// ===== src/utf32_to_utf8_utf16_encoder_core.sv =====
// UTF-32 to UTF-8 / UTF-16 encoder.
// din carries one 32-bit code word, the target mode (0 UTF-8, 1 UTF-16) and
// the room left downstream. dout carries one unit per word: the byte or
// UTF-16 unit, the unit count of that code point, last on the final unit and
// error on the error word. The APB register at offset 0 selects
// little-endian order for the input word and the UTF-16 units.
// An accepted word sits in the input register; while dout is not stalled,
// one unit of it per cycle is encoded and loaded into the output register,
// from which it leaves on dout. A word produces 1 to 4 units. The next word
// is accepted in the cycle its predecessor's final unit leaves the input
// register, so units stream at one per cycle while dout is not stalled.
// Not enough room, or a set error, gives a single error word with count 0;
// the error stays set until reset.
// Reset clears both registers' valid state, the error and the byte order.
// When dout stalls, the output register holds its word and the input
// register holds its word and unit index; din drops ready once both are full.
module utf32_to_utf8_utf16_encoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	u2e_in_if.sink                         din,
	u2e_out_if.source                      dout,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [u2e_pkg::AddrWidth-1:0]  paddr,
	input  logic [u2e_pkg::DataWidth-1:0]  pwdata,
	output logic [u2e_pkg::DataWidth-1:0]  prdata,
	output logic                           pready
);
	import u2e_pkg::*;

	logic        byte_swap;
	logic        valid_s1;
	logic [31:0] code_word_s1;
	logic        mode_s1;
	logic [2:0]  room_s1;
	logic [1:0]  idx_q;
	logic        error_q;
	logic        out_valid_q;
	unit_t       out_q;
	unit_t       unit;
	logic        out_load;
	logic        advance;
	logic        take;

	u2e_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.byte_swap (byte_swap)
	);

	u2e_encode u_encode (
		.code_word  (code_word_s1),
		.mode       (mode_s1),
		.room       (room_s1),
		.byte_swap  (byte_swap),
		.error_flag (error_q),
		.idx        (idx_q),
		.unit       (unit)
	);

	// Handshake decisions
	assign out_load  = !out_valid_q || dout.ready;
	assign advance   = valid_s1 && out_load;
	assign din.ready = !valid_s1 || (advance && unit.last);
	assign take      = din.valid && din.ready;

	// Hold the word and step through its units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance && unit.last) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				idx_q <= unit.last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_word_s1 <= din.code_word;
			mode_s1      <= din.mode;
			room_s1      <= din.room;
		end
	end

	// Latch the sticky error as its word is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q <= 1'b0;
		end else if (advance && unit.error) begin
			error_q <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= unit;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.unit_value = out_q.unit_value;
	assign dout.unit_count = out_q.unit_count;
	assign dout.last       = out_q.last;
	assign dout.error      = out_q.error;

`ifndef SYNTHESIS
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(error_q))
		else $error("sticky error cleared");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !unit.error |-> ({1'b0, idx_q} < unit.unit_count))
		else $error("unit index beyond unit count");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.error |-> dout.unit_count == 3'd0 && dout.last)
		else $error("malformed error word");

	a_error_follows: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.ready && dout.error |=> !dout.valid || dout.error)
		else $error("word without error after error");

	a_idx_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> idx_q == 2'd0)
		else $error("new word does not start at first unit");
`endif

endmodule

// ===== src/u2e_apb_regs.sv =====
module u2e_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [u2e_pkg::AddrWidth-1:0]  paddr,
	input  logic [u2e_pkg::DataWidth-1:0]  pwdata,
	output logic [u2e_pkg::DataWidth-1:0]  prdata,
	output logic                           pready,
	output logic                           byte_swap
);
	import u2e_pkg::*;

	logic byte_swap_q;
	logic reg_hit;

	// Decode the word index of the access
	assign reg_hit = (paddr[AddrWidth-1] == RegLittleEndian);
	assign pready  = 1'b1;

	// Write the byte-order register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_swap_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			byte_swap_q <= pwdata[0];
		end
	end

	// Return the register, zero elsewhere
	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata[0] = byte_swap_q;
		end
	end

	assign byte_swap = byte_swap_q;

endmodule

// ===== src/u2e_encode.sv =====
module u2e_encode (
	input  logic [31:0]     code_word,
	input  logic            mode,
	input  logic [2:0]      room,
	input  logic            byte_swap,
	input  logic            error_flag,
	input  logic [1:0]      idx,
	output u2e_pkg::unit_t  unit
);
	import u2e_pkg::*;

	logic [31:0]      cp;
	logic [2:0]       n;
	logic             fail;
	logic [20:0]      d;
	logic [3:0][15:0] units;
	logic [15:0]      hi_unit;
	logic [15:0]      lo_unit;

	// Restore big-endian order before classifying
	assign cp = byte_swap ? swap32(code_word) : code_word;
	assign d  = cp[20:0] - SupplBase;

	// Count the units the code point needs
	always_comb begin
		if (mode_t'(mode) == MODE_UTF16) begin
			n = (cp[31:16] == 16'h0000) ? 3'd1 : 3'd2;
		end else if (cp < Utf8Limit1) begin
			n = 3'd1;
		end else if (cp < Utf8Limit2) begin
			n = 3'd2;
		end else if (cp < Utf8Limit3) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
	end

	assign fail = error_flag || (n > room);

	// Build the surrogate pair
	assign hi_unit = HighSurr | {5'b0, d[20:10]};
	assign lo_unit = LowSurr | {6'b0, d[9:0]};

	// Lay out every unit of the sequence
	always_comb begin
		units = '0;
		if (mode_t'(mode) == MODE_UTF16) begin
			if (n == 3'd1) begin
				units[0] = cp[15:0];
			end else begin
				units[0] = hi_unit;
				units[1] = lo_unit;
			end
			if (byte_swap) begin
				units[0] = swap16(units[0]);
				units[1] = swap16(units[1]);
			end
		end else begin
			unique case (n)
				3'd1: begin
					units[0] = {9'b0, cp[6:0]};
				end
				3'd2: begin
					units[0] = {8'b0, Utf8Lead2 | {3'b0, cp[10:6]}};
					units[1] = {8'b0, Utf8Cont | {2'b0, cp[5:0]}};
				end
				3'd3: begin
					units[0] = {8'b0, Utf8Lead3 | {4'b0, cp[15:12]}};
					units[1] = {8'b0, Utf8Cont | {2'b0, cp[11:6]}};
					units[2] = {8'b0, Utf8Cont | {2'b0, cp[5:0]}};
				end
				default: begin
					units[0] = {8'b0, Utf8Lead4 | {5'b0, cp[20:18]}};
					units[1] = {8'b0, Utf8Cont | {2'b0, cp[17:12]}};
					units[2] = {8'b0, Utf8Cont | {2'b0, cp[11:6]}};
					units[3] = {8'b0, Utf8Cont | {2'b0, cp[5:0]}};
				end
			endcase
		end
	end

	// Pick the current unit, or the single error word
	always_comb begin
		if (fail) begin
			unit.unit_value = '0;
			unit.unit_count = '0;
			unit.last       = 1'b1;
			unit.error      = 1'b1;
		end else begin
			unit.unit_value = units[idx];
			unit.unit_count = n;
			unit.last       = ({1'b0, idx} == (n - 3'd1));
			unit.error      = 1'b0;
		end
	end

endmodule
